[hw/rtl/ifc_pkg.sv]
// ----------------------------------------------------------------------------
// ifc_pkg: irrigation and fan controller shared definitions
// Command codes, register indexes, reset values and the structs passed
// between the configuration, core and result stages.
// ----------------------------------------------------------------------------
package ifc_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned RunMsW    = 22;
  localparam int unsigned CoolMsW   = 27;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned MsPerSec  = 1000;
  localparam int unsigned FanHystW  = 12;

  localparam logic [FanHystW-1:0] FAN_HYST_TENTHS = 12'd20;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_MANUAL = 2'd2
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOISTURE_MIN = 3'd0,
    REG_TEMP_MAX     = 3'd1,
    REG_WATER_CRIT   = 3'd2,
    REG_RUN_SECONDS  = 3'd3,
    REG_COOL_SECONDS = 3'd4
  } reg_idx_t;

  localparam logic [9:0]         MOISTURE_MIN_RST = 10'd300;
  localparam logic [10:0]        TEMP_MAX_RST     = 11'd300;
  localparam logic [13:0]        WATER_CRIT_RST   = 14'd100;
  localparam logic [RunMsW-1:0]  RUN_MS_RST       = 22'd60000;
  localparam logic [CoolMsW-1:0] COOL_MS_RST      = 27'd600000;

  typedef struct packed {
    logic [9:0]         moisture_min;
    logic [10:0]        temp_max;
    logic [13:0]        water_crit;
    logic [RunMsW-1:0]  run_ms;
    logic [CoolMsW-1:0] cool_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [10:0]       soil_moisture_a;
    logic [10:0]       soil_moisture_b;
    logic [11:0]       air_temperature;
    logic [14:0]       water_level;
    logic [RunMsW-1:0] manual_ms;
  } item_t;

  typedef struct packed {
    logic water_alert;
    logic cooldown_active;
    logic action_taken;
    logic fan_running;
    logic pump_running;
    logic valve_open;
  } result_t;

endpackage

[hw/rtl/ifc_cfg.sv]
// ----------------------------------------------------------------------------
// ifc_cfg: configuration registers
// Holds the thresholds and keeps run and cooldown lengths in milliseconds,
// scaled once at write time.
// ----------------------------------------------------------------------------
module ifc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ifc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ifc_pkg::CfgDataW-1:0] cfg_wdata,
  output ifc_pkg::cfg_t                cfg
);

  ifc_pkg::cfg_t cfg_r;
  ifc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ifc_pkg::REG_MOISTURE_MIN: cfg_nxt.moisture_min = cfg_wdata[9:0];
        ifc_pkg::REG_TEMP_MAX:     cfg_nxt.temp_max     = cfg_wdata[10:0];
        ifc_pkg::REG_WATER_CRIT:   cfg_nxt.water_crit   = cfg_wdata[13:0];
        ifc_pkg::REG_RUN_SECONDS:
          cfg_nxt.run_ms = {10'd0, cfg_wdata[11:0]} *
                           ifc_pkg::RunMsW'(ifc_pkg::MsPerSec);
        ifc_pkg::REG_COOL_SECONDS:
          cfg_nxt.cool_ms = {10'd0, cfg_wdata} *
                            ifc_pkg::CoolMsW'(ifc_pkg::MsPerSec);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.moisture_min <= ifc_pkg::MOISTURE_MIN_RST;
      cfg_r.temp_max     <= ifc_pkg::TEMP_MAX_RST;
      cfg_r.water_crit   <= ifc_pkg::WATER_CRIT_RST;
      cfg_r.run_ms       <= ifc_pkg::RUN_MS_RST;
      cfg_r.cool_ms      <= ifc_pkg::COOL_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/ifc_core.sv]
// ----------------------------------------------------------------------------
// ifc_core: controller state and item evaluation
// Evaluates one registered item against the run, cooldown and fan state and
// commits the new state when the item moves on to the result register.
// ----------------------------------------------------------------------------
module ifc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ifc_pkg::item_t   item,
  input  ifc_pkg::cfg_t    cfg,
  output ifc_pkg::result_t result
);

  logic [ifc_pkg::TimeW-1:0]  time_ms_r, time_ms_nxt;
  logic                       irrigating_r, irrigating_nxt;
  logic [ifc_pkg::TimeW-1:0]  run_start_ms_r, run_start_ms_nxt;
  logic [ifc_pkg::RunMsW-1:0] run_length_ms_r, run_length_ms_nxt;
  logic [ifc_pkg::TimeW-1:0]  last_end_ms_r, last_end_ms_nxt;
  logic                       ended_once_r, ended_once_nxt;
  logic                       fan_state_r, fan_state_nxt;

  logic [ifc_pkg::TimeW-1:0] run_elapsed;
  logic [ifc_pkg::TimeW-1:0] since_end;
  logic       run_done;
  logic       irr_mid;
  logic       cool_win;
  logic       a_ok, b_ok;
  logic [11:0] moist_sum;
  logic [10:0] min2;
  logic       want;
  logic       level_low;
  logic       temp_ok, temp_hot, temp_cold;
  logic       action, cool, alert;

  assign run_elapsed = time_ms_r - run_start_ms_r;
  assign run_done    = irrigating_r &&
                       (run_elapsed >= {{(ifc_pkg::TimeW-ifc_pkg::RunMsW){1'b0}},
                                        run_length_ms_r});
  assign irr_mid     = irrigating_r && !run_done;

  // a run that ends on this sample restarts the cooldown window at zero
  assign since_end = run_done ? '0 : (time_ms_r - last_end_ms_r);
  assign cool_win  = (ended_once_r || run_done) &&
                     (since_end < {{(ifc_pkg::TimeW-ifc_pkg::CoolMsW){1'b0}}, cfg.cool_ms});

  // average compared as a sum against twice the minimum
  assign a_ok      = !item.soil_moisture_a[10];
  assign b_ok      = !item.soil_moisture_b[10];
  assign moist_sum = {1'b0, item.soil_moisture_a} + {1'b0, item.soil_moisture_b};
  assign min2      = {cfg.moisture_min, 1'b0};

  always_comb begin
    if (a_ok && b_ok)
      want = moist_sum < {1'b0, min2};
    else if (a_ok)
      want = {item.soil_moisture_a[9:0], 1'b0} < min2;
    else if (b_ok)
      want = {item.soil_moisture_b[9:0], 1'b0} < min2;
    else
      want = 1'b0;
  end

  assign level_low = item.water_level[14] || (item.water_level[13:0] < cfg.water_crit);

  assign temp_ok   = !item.air_temperature[11];
  assign temp_hot  = item.air_temperature[10:0] > cfg.temp_max;
  assign temp_cold = ({1'b0, item.air_temperature[10:0]} + ifc_pkg::FAN_HYST_TENTHS) <
                     {1'b0, cfg.temp_max};

  always_comb begin
    time_ms_nxt       = time_ms_r;
    irrigating_nxt    = irrigating_r;
    run_start_ms_nxt  = run_start_ms_r;
    run_length_ms_nxt = run_length_ms_r;
    last_end_ms_nxt   = last_end_ms_r;
    ended_once_nxt    = ended_once_r;
    fan_state_nxt     = fan_state_r;
    action            = 1'b0;
    cool              = 1'b0;
    alert             = 1'b0;
    case (item.command)
      ifc_pkg::CMD_TICK: begin
        time_ms_nxt = time_ms_r + ifc_pkg::TimeW'(1);
      end
      ifc_pkg::CMD_SAMPLE: begin
        if (run_done) begin
          irrigating_nxt  = 1'b0;
          last_end_ms_nxt = time_ms_r;
          ended_once_nxt  = 1'b1;
        end
        if (!irr_mid && want) begin
          if (cool_win) begin
            cool = 1'b1;
          end else if (level_low) begin
            alert = 1'b1;
          end else begin
            irrigating_nxt    = 1'b1;
            run_start_ms_nxt  = time_ms_r;
            run_length_ms_nxt = cfg.run_ms;
            action            = 1'b1;
          end
        end
        if (temp_ok) begin
          if (temp_hot) begin
            if (!fan_state_r) begin
              fan_state_nxt = 1'b1;
              action        = 1'b1;
            end
          end else if (temp_cold) begin
            if (fan_state_r) begin
              fan_state_nxt = 1'b0;
              action        = 1'b1;
            end
          end
        end
      end
      ifc_pkg::CMD_MANUAL: begin
        if (!irrigating_r) begin
          irrigating_nxt    = 1'b1;
          run_start_ms_nxt  = time_ms_r;
          run_length_ms_nxt = item.manual_ms;
          action            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_ms_r       <= '0;
      irrigating_r    <= 1'b0;
      run_start_ms_r  <= '0;
      run_length_ms_r <= '0;
      last_end_ms_r   <= '0;
      ended_once_r    <= 1'b0;
      fan_state_r     <= 1'b0;
    end else if (fire) begin
      time_ms_r       <= time_ms_nxt;
      irrigating_r    <= irrigating_nxt;
      run_start_ms_r  <= run_start_ms_nxt;
      run_length_ms_r <= run_length_ms_nxt;
      last_end_ms_r   <= last_end_ms_nxt;
      ended_once_r    <= ended_once_nxt;
      fan_state_r     <= fan_state_nxt;
    end
  end

  assign result.valve_open      = irrigating_nxt;
  assign result.pump_running    = irrigating_nxt;
  assign result.fan_running     = fan_state_nxt;
  assign result.action_taken    = action;
  assign result.cooldown_active = cool;
  assign result.water_alert     = alert;

endmodule

[hw/rtl/ifc_out.sv]
// ----------------------------------------------------------------------------
// ifc_out: result register
// Holds one result until the downstream transfer and reports whether a new
// result can be loaded this cycle.
// ----------------------------------------------------------------------------
module ifc_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ifc_pkg::result_t result,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output ifc_pkg::result_t out_result
);

  logic             vld_r, vld_nxt;
  ifc_pkg::result_t res_r;

  assign can_load = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load)
      vld_nxt = 1'b1;
    else if (out_tready)
      vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign out_result = res_r;

endmodule

[hw/rtl/irrigation_and_fan_controller_top.sv]
// ----------------------------------------------------------------------------
// irrigation_and_fan_controller_top: irrigation and fan controller
// Stream front end with input register, controller core and result register.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result. An item is registered on
// input, evaluated against the controller state and written to the result
// register, from which it is offered for an output transfer. Throughput is
// one item per cycle as long as the result side takes results; a stalled
// result register stops the input register, and in_tready follows
// out_tready through that two-entry path. Run and cooldown lengths are
// scaled to milliseconds when their registers are written.
// ----------------------------------------------------------------------------
module irrigation_and_fan_controller_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // slave side
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [10:0] soil_moisture_a, [21:11] soil_moisture_b, [33:22] air_temperature,
  // [48:34] water_level, [60:49] manual_seconds, [63:61] zero
  input  logic [63:0]                  in_tdata,
  // [1:0] command
  input  logic [1:0]                   in_tuser,
  // master side
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] valve_open, [1] pump_running, [2] fan_running, [3] action_taken,
  // [4] cooldown_active, [5] water_alert, [7:6] zero
  output logic [7:0]                   out_tdata,
  // configuration
  input  logic                         cfg_we,
  input  logic [ifc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ifc_pkg::CfgDataW-1:0] cfg_wdata
);

  ifc_pkg::cfg_t    cfg;
  ifc_pkg::item_t   item_r;
  ifc_pkg::item_t   item_nxt;
  ifc_pkg::result_t core_res;
  ifc_pkg::result_t out_res;
  logic             s1_vld_r, s1_vld_nxt;
  logic             can_load;
  logic             s1_adv;
  logic             in_xfer;

  assign s1_adv    = s1_vld_r && can_load;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // scale the manual length to milliseconds on the way in
  always_comb begin
    item_nxt.command         = in_tuser;
    item_nxt.soil_moisture_a = in_tdata[10:0];
    item_nxt.soil_moisture_b = in_tdata[21:11];
    item_nxt.air_temperature = in_tdata[33:22];
    item_nxt.water_level     = in_tdata[48:34];
    item_nxt.manual_ms       = {10'd0, in_tdata[60:49]} *
                               ifc_pkg::RunMsW'(ifc_pkg::MsPerSec);
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer)
      s1_vld_nxt = 1'b1;
    else if (s1_adv)
      s1_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
  end

  ifc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  ifc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .result     (core_res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_res)
  );

  assign out_tdata = {2'b00, out_res};

`ifndef NO_ASSERTIONS
  // a blocked start never coexists with the other block reason or a running valve
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.cooldown_active || out_res.water_alert) |->
      !(out_res.cooldown_active && out_res.water_alert) && !out_res.valve_open)
    else $error("blocked start reported with conflicting status");

  // an input transfer always leaves an item in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_vld_r)
    else $error("accepted item lost from input register");

  // full input register behind a stalled result register must back-pressure
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is full and stalled");

  // a transfer into the result register shows up as valid next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("result dropped on load");
`endif

endmodule

[sim/irrigation_and_fan_controller_tb.sv]
// ----------------------------------------------------------------------------
// testbench: irrigation and fan controller stream test
// Drives ticks, sensor samples, manual starts and the unused command code
// through the input stream, predicts every result from a local model of the
// run, cooldown and fan state, and checks each result transfer in order.
// Settings move through reset values, register extremes, second-scale run
// timing and random mixes, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ifc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IdleLimit = 2000;

  typedef struct {
    logic [1:0]         command;
    logic signed [10:0] moist_a;
    logic signed [10:0] moist_b;
    logic signed [11:0] temp;
    logic signed [14:0] level;
    logic [11:0]        manual_sec;
  } sensor_item_t;

  typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_style_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // controller settings as last written
  bit [9:0]  moist_min = 10'd300;
  bit [10:0] temp_max = 11'd300;
  bit [13:0] water_crit = 14'd100;
  bit [11:0] run_sec = 12'd60;
  bit [16:0] cool_sec = 17'd600;

  // controller state
  bit [31:0] clock_ms = '0;
  bit        watering = 1'b0;
  bit [31:0] start_ms = '0;
  bit [21:0] length_ms = '0;
  bit [31:0] end_ms = '0;
  bit        has_ended = 1'b0;
  bit        fan_on = 1'b0;

  result_t   expected_results[$];
  int        failures = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;

  rx_style_t rx_style = RX_STEADY;
  bit [15:0] rx_pattern = 16'hffff;
  bit [3:0]  rx_step = '0;
  int        rx_hold_cycles = 0;

  irrigation_and_fan_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic void start_run(bit [11:0] seconds);
    watering = 1'b1;
    start_ms = clock_ms;
    length_ms = 22'(32'(seconds) * 32'd1000);
  endfunction

  // Advance the controller state by one item and return its result.
  function automatic result_t predict_result(sensor_item_t it);
    result_t   r;
    int        ma, mb, t, lv, lo2, hi;
    bit        want;
    bit [31:0] since_end;
    r = '0;
    want = 1'b0;
    ma = it.moist_a;
    mb = it.moist_b;
    t = it.temp;
    lv = it.level;
    lo2 = 2 * int'(moist_min);
    hi = int'(temp_max);
    case (it.command)
      CMD_TICK: clock_ms = clock_ms + 32'd1;
      CMD_SAMPLE: begin
        if (watering && clock_ms - start_ms >= {10'd0, length_ms}) begin
          watering = 1'b0;
          end_ms = clock_ms;
          has_ended = 1'b1;
        end
        if (!watering) begin
          // average of the valid readings, compared without rounding
          if (ma >= 0 && mb >= 0) want = (ma + mb) < lo2;
          else if (ma >= 0) want = 2 * ma < lo2;
          else if (mb >= 0) want = 2 * mb < lo2;
          since_end = clock_ms - end_ms;
          if (want) begin
            if (has_ended && 64'(since_end) < 64'(cool_sec) * 64'd1000) begin
              r.cooldown_active = 1'b1;
            end else if (lv < 0 || lv < int'(water_crit)) begin
              r.water_alert = 1'b1;
            end else begin
              start_run(run_sec);
              r.action_taken = 1'b1;
            end
          end
        end
        if (t >= 0) begin
          if (t > hi) begin
            if (!fan_on) begin
              fan_on = 1'b1;
              r.action_taken = 1'b1;
            end
          end else if (t < hi - int'(FAN_HYST_TENTHS)) begin
            if (fan_on) begin
              fan_on = 1'b0;
              r.action_taken = 1'b1;
            end
          end
        end
      end
      CMD_MANUAL: begin
        if (!watering) begin
          start_run(it.manual_sec);
          r.action_taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.valve_open = watering;
    r.pump_running = watering;
    r.fan_running = fan_on;
    return r;
  endfunction

  function automatic sensor_item_t control_item(logic [1:0] cmd, int seconds);
    sensor_item_t it;
    it.command = cmd;
    it.moist_a = 11'($urandom);
    it.moist_b = 11'($urandom);
    it.temp = 12'($urandom);
    it.level = 15'($urandom);
    it.manual_sec = 12'(seconds);
    return it;
  endfunction

  function automatic sensor_item_t sample_item(int ma, int mb, int t, int lv);
    sensor_item_t it;
    it = control_item(CMD_SAMPLE, $urandom);
    it.moist_a = 11'(ma);
    it.moist_b = 11'(mb);
    it.temp = 12'(t);
    it.level = 15'(lv);
    return it;
  endfunction

  function automatic int moisture_value();
    case ($urandom_range(0, 7))
      0: return int'($urandom_range(0, 2047)) - 1024;
      1: return -1;
      2: return 1000;
      default: return int'(moist_min) + int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic sensor_item_t random_item();
    sensor_item_t it;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it = control_item(CMD_TICK, $urandom);
    else if (pick < 85) it = control_item(CMD_SAMPLE, $urandom);
    else if (pick < 95) it = control_item(CMD_MANUAL, 0);
    else it = control_item(CMD_UNUSED, $urandom);
    if (it.command == CMD_SAMPLE) begin
      it.moist_a = 11'(moisture_value());
      it.moist_b = 11'(moisture_value());
      case ($urandom_range(0, 4))
        0: it.temp = 12'($urandom);
        1: it.temp = '1;
        default: it.temp = 12'(int'(temp_max) + int'($urandom_range(0, 50)) - 35);
      endcase
      case ($urandom_range(0, 4))
        0: it.level = 15'($urandom);
        1: it.level = '1;
        default: it.level = 15'(int'(water_crit) + int'($urandom_range(0, 8)) - 4);
      endcase
    end
    // a long manual run would block auto starts for the rest of the phase
    if (it.command == CMD_MANUAL && watering) it.manual_sec = 12'($urandom);
    return it;
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(sensor_item_t it);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= it.command;
    in_tdata <= {3'b000, it.manual_sec, it.level, it.temp, it.moist_b, it.moist_a};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_result(it));
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_item(control_item(CMD_TICK, $urandom));
  endtask

  task automatic pause_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom, $urandom};
      in_tuser <= 2'($urandom);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, bit [16:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_MOISTURE_MIN: moist_min = value[9:0];
      REG_TEMP_MAX:     temp_max = value[10:0];
      REG_WATER_CRIT:   water_crit = value[13:0];
      REG_RUN_SECONDS:  run_sec = value[11:0];
      REG_COOL_SECONDS: cool_sec = value[16:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(bit [16:0] m, bit [16:0] t, bit [16:0] w,
                                bit [16:0] r, bit [16:0] c);
    cfg_write(REG_MOISTURE_MIN, m);
    cfg_write(REG_TEMP_MAX, t);
    cfg_write(REG_WATER_CRIT, w);
    cfg_write(REG_RUN_SECONDS, r);
    cfg_write(REG_COOL_SECONDS, c);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset settings: alerts, fan hysteresis, faulted sensors, manual starts
  // and a cooldown right after a zero-length run.
  task automatic test_reset_defaults();
    send_item(control_item(CMD_TICK, 4095));
    send_item(control_item(CMD_UNUSED, $urandom));
    send_item(sample_item(200, 200, 300, 99));
    send_item(sample_item(-1, 299, 301, -1));
    send_item(sample_item(299, -1024, 280, -16384));
    send_item(sample_item(-1, -1, 279, 10000));
    send_item(sample_item(300, 300, -1, 100));
    send_item(sample_item(1023, 1023, 2047, 16383));
    send_item(sample_item(-1024, -1024, -2048, -16384));
    send_item(control_item(CMD_MANUAL, 0));
    send_item(control_item(CMD_MANUAL, 4095));
    send_item(sample_item(0, 0, 0, 16383));
    send_item(control_item(CMD_TICK, 0));
    send_item(sample_item(0, 0, 100, 100));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    apply_settings(0, 0, 0, 0, 0);
    send_item(sample_item(0, 0, 1, 0));
    send_item(sample_item(-1, 0, -1, -1));
    wait_drained();
    apply_settings(1023, 2047, 16383, 0, 0);
    send_item(sample_item(1023, 1022, 2047, 16382));
    send_item(sample_item(1023, 1022, 2026, 16383));
    wait_drained();
    apply_settings(1023, 2047, 16383, 0, 131071);
    send_item(sample_item(1022, 1023, 2027, 16383));
    wait_drained();
  endtask

  // Zero-length and one-second runs: a zero-length run ends on the next
  // sample and opens the cooldown, a manual start ignores the cooldown, and
  // a run in progress blocks both kinds of start.
  task automatic test_run_timing();
    apply_settings(500, 300, 100, 1, 1);
    send_item(sample_item(900, 900, 310, 500));
    send_item(control_item(CMD_MANUAL, 0));
    send_ticks(3);
    send_item(sample_item(100, 100, 200, 500));
    send_ticks(5);
    send_item(sample_item(100, -3, 320, 500));
    send_item(control_item(CMD_MANUAL, 1));
    send_ticks(10);
    send_item(sample_item(100, 100, 250, 500));
    send_item(control_item(CMD_MANUAL, 2));
    send_ticks(1);
    send_item(sample_item(-3, 100, 320, 500));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int p = 0; p < 6; p++) begin
      apply_settings($urandom_range(0, 1023), $urandom_range(0, 2047),
                     $urandom_range(0, 16383), 0, (p == 2) ? $urandom_range(1, 3) : 0);
      rx_style = rx_style_t'(p % 3);
      rx_pattern = 16'($urandom) | 16'h0101;
      sent = 0;
      while (sent < 105) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          send_item(random_item());
          sent++;
          // let the sink back up while items keep coming
          if (sent == 40 && p % 2 == 1) rx_hold_cycles = $urandom_range(40, 80);
          if (sent == 80 && p % 2 == 0) wait_drained();
        end
        if (p != 0 && $urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
      end
      wait_drained();
    end
  endtask

  // sink ready: a long hold-off when requested, otherwise the phase style
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      case (rx_style)
        RX_STEADY: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_tready <= rx_pattern[rx_step];
          rx_step <= rx_step + 4'd1;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    result_t    want_r;
    logic [7:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result %0d: 0x%02h arrived with nothing expected",
                               results_seen, got));
      end else begin
        want_r = expected_results.pop_front();
        if (got !== {2'b00, want_r}) begin
          note_failure($sformatf({"result %0d: expected valve %b pump %b fan %b",
                                  " action %b cool %b alert %b pad %b, got",
                                  " valve %b pump %b fan %b action %b cool %b",
                                  " alert %b pad %b"}, results_seen,
                                 want_r.valve_open, want_r.pump_running,
                                 want_r.fan_running, want_r.action_taken,
                                 want_r.cooldown_active, want_r.water_alert, 2'b00,
                                 got[0], got[1], got[2], got[3], got[4], got[5],
                                 got[7:6]));
        end
      end
    end
  end

  // count cycles with no transfer on either stream and no register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_run_timing();
    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
